>>> rtl/bmpd_pkg.sv
// Package for the bitmap pixel stream decoder: payload structs, codes and constants.
// Used by every module of the block; depends on nothing.
package bmpd_pkg;

    localparam int PALETTE_ENTRIES_DEF = 256;
    localparam int MAX_COLUMNS_DEF     = 4096;
    localparam int CFG_W               = 13;
    localparam int CFG_IDX_W           = 3;

    localparam logic [2:0] SRC_1BPP  = 3'd0;
    localparam logic [2:0] SRC_2BPP  = 3'd1;
    localparam logic [2:0] SRC_4BPP  = 3'd2;
    localparam logic [2:0] SRC_8BPP  = 3'd3;
    localparam logic [2:0] SRC_24BPP = 3'd4;
    localparam logic [2:0] SRC_32BPP = 3'd5;

    localparam logic [1:0] FMT_RGB565 = 2'd0;
    localparam logic [1:0] FMT_RGB24  = 2'd1;
    localparam logic [1:0] FMT_BGRA32 = 2'd2;

    localparam logic [2:0] REG_SRC_BITS  = 3'd0;
    localparam logic [2:0] REG_PAL_COUNT = 3'd1;
    localparam logic [2:0] REG_OUT_FMT   = 3'd2;
    localparam logic [2:0] REG_WIDTH     = 3'd3;
    localparam logic [2:0] REG_HEIGHT    = 3'd4;
    localparam logic [2:0] REG_X_OFFSET  = 3'd5;
    localparam logic [2:0] REG_DST_W     = 3'd6;
    localparam logic [2:0] REG_DST_H     = 3'd7;

    localparam logic OP_PIXEL   = 1'b0;
    localparam logic OP_PALETTE = 1'b1;

    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
        logic [7:0] pal_index;
        logic [7:0] pal_red;
        logic [7:0] pal_green;
        logic [7:0] pal_blue;
    } in_item_t;

    typedef struct packed {
        logic [11:0] column;
        logic [11:0] row;
        logic [31:0] pixel_word;
        logic [7:0]  alpha;
        logic        last_of_item;
    } out_item_t;

    // Controller to datapath.
    typedef struct packed {
        logic       take_byte;   // latch byte and start its pixels
        logic       emit;        // present one pixel at the output register
        logic       restart;     // configuration written
    } dp_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic       more;        // another pixel pending for the current byte
        logic       ready;       // the pending pixel's colour is settled
        logic       active;      // stream live: geometry ok and not finished
    } dp_status_t;

    function automatic logic [31:0] pack_pixel(input logic [1:0] fmt,
                                               input logic [23:0] rgb,
                                               input logic [7:0] a);
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [31:0] w;
        r = rgb[23:16];
        g = rgb[15:8];
        b = rgb[7:0];
        unique case (fmt)
            FMT_RGB565: w = {16'd0, r[7:3], g[7:2], b[7:3]};
            FMT_RGB24:  w = {8'd0, b, g, r};
            FMT_BGRA32: w = {a, r, g, b};
            default:    w = 32'd0;
        endcase
        return w;
    endfunction

endpackage

>>> rtl/bmp_pixel_stream_decoder.sv
// Top level of the bitmap pixel stream decoder: joins controller and datapath.
// Depends on bmpd_pkg, bmpd_ctrl and bmpd_datapath.
//
// Usage: write the configuration registers on cfg_we/cfg_index/cfg_data while
// idle, then send beats on in_valid/in_stall. A beat with op set writes one
// palette entry. A pixel data beat yields 0 to 8 output beats on
// out_valid/out_stall, bottom row first, with last_of_item on the final
// pixel of that byte. Every register write restarts the pixel stream.
// Flow: one byte is worked on at a time and the input stalls meanwhile.
// Each sub-byte pixel is first set up from the buffered byte; palette
// pixels are then read into the palette read register before they enter
// the output register. An 8-bit index at or above the palette count is
// first reduced by repeated subtraction of the count. The next beat is
// taken once the byte's last pixel is loaded, or after a byte with none.
// Reset initialises the counters and control state; the palette is undefined
// until written. A stalled receiver holds the output register and the block
// stops taking input until the pixel is taken.
module bmp_pixel_stream_decoder
    import bmpd_pkg::*;
#(
    parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF,
    parameter int MAX_COLUMNS     = MAX_COLUMNS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_item_t            out_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       in_accept;

    assign in_accept = in_valid && !in_stall;

    bmpd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_op     (in_data.op),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cfg_we    (cfg_we),
        .status    (status),
        .cmd       (cmd)
    );

    bmpd_datapath #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES),
        .MAX_COLUMNS     (MAX_COLUMNS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (in_accept),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_data  (out_data)
    );

`ifndef SYNTHESIS
    a_no_take_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take_byte |-> !status.more)
        else $error("byte taken while pixels still pending");
    a_take_needs_beat: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take_byte |-> in_accept)
        else $error("byte started without an accepted beat");
    a_stall_while_work: assert property (@(posedge clk) disable iff (!rst_n)
        status.more |-> in_stall)
        else $error("input open while a byte is being unpacked");
`endif

endmodule

>>> rtl/bmpd_ctrl.sv
// Controller for the bitmap pixel stream decoder: input/output handshake sequencing.
// Depends on bmpd_pkg.
module bmpd_ctrl
    import bmpd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_op,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    input  logic       cfg_we,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;
    logic   accept;

    // The output register can take a new pixel when empty or being drained.
    assign slot_free = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE) || !slot_free;
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        cmd.restart    = cfg_we;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_op == OP_PIXEL && status.active)
                begin
                    cmd.take_byte = 1'b1;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!status.more)
                begin
                    state_next = ST_IDLE;
                end
                else if (slot_free && status.ready)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> rtl/bmpd_datapath.sv
// Datapath for the bitmap pixel stream decoder: registers, palette memory,
// unpacking, counters and output register. Depends on bmpd_pkg.
module bmpd_datapath
    import bmpd_pkg::*;
#(
    parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF,
    parameter int MAX_COLUMNS     = MAX_COLUMNS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_accept,
    input  in_item_t             in_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  dp_cmd_t              cmd,
    output dp_status_t           status,
    output out_item_t            out_data
);

    localparam int PAL_AW = $clog2(PALETTE_ENTRIES);

    logic [2:0]  src_reg;
    logic [8:0]  pal_cnt_reg;
    logic [1:0]  fmt_reg;
    logic [11:0] width_reg, height_reg, xoff_reg;
    logic [12:0] dst_w_reg, dst_h_reg;

    logic [23:0] palette_mem [PALETTE_ENTRIES];

    logic [7:0]  buf_reg, buf_next;
    logic [3:0]  bits_reg, bits_next;
    logic [1:0]  phase_reg, phase_next;
    logic [23:0] partial_reg, partial_next;
    logic [14:0] rbc_reg, rbc_next;
    logic [11:0] col_reg, col_next;
    logic [11:0] rowc_reg, rowc_next;
    logic        fin_reg, fin_next;
    logic        geo_ok;
    logic [8:0]  ncol;

    // Per-byte pending work: pixel kind and how the colour is found.
    logic        pend_reg, pend_next;
    logic        use_pal_reg, use_pal_next;
    logic [7:0]  pidx_reg, pidx_next;
    logic [23:0] prgb_reg, prgb_next;
    logic [7:0]  palpha_reg, palpha_next;
    logic        idx_pend_reg, idx_pend_next;
    logic        rowend_reg, rowend_next;
    logic        lookup_reg, lookup_next;
    logic [23:0] rd_reg;

    // 8-bit index reduction: iterative subtract, one step per cycle.
    logic        mod_busy_reg, mod_busy_next;
    logic [7:0]  mod_val_reg, mod_val_next;

    out_item_t   out_reg;

    logic [3:0]  bpp;
    logic [7:0]  vmask, grey;
    logic [8:0]  need;
    logic [3:0]  bits_sub;
    logic [7:0]  v;
    logic [12:0] right;
    logic        last_pix;

    always_comb
    begin
        unique case (src_reg)
            SRC_1BPP: begin bpp = 4'd1; vmask = 8'h01; grey = 8'd255; need = 9'd2;  end
            SRC_2BPP: begin bpp = 4'd2; vmask = 8'h03; grey = 8'd64;  need = 9'd4;  end
            default:  begin bpp = 4'd4; vmask = 8'h0f; grey = 8'd16;  need = 9'd16; end
        endcase
    end

    assign bits_sub = bits_reg - bpp;
    assign v        = (buf_reg >> bits_sub) & vmask;
    assign right    = {1'b0, xoff_reg} + {1'b0, width_reg};

    // A pixel is ready when the colour source is settled.
    logic ready_pix;
    assign ready_pix     = pend_reg && !mod_busy_reg && !lookup_reg;
    assign status.more   = pend_reg;
    assign status.ready  = ready_pix && !idx_pend_reg;
    assign status.active = geo_ok && !fin_reg && src_reg <= SRC_32BPP;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_reg     <= SRC_8BPP;
            pal_cnt_reg <= 9'd0;
            fmt_reg     <= FMT_BGRA32;
            width_reg   <= 12'd0;
            height_reg  <= 12'd0;
            xoff_reg    <= 12'd0;
            dst_w_reg   <= 13'd4096;
            dst_h_reg   <= 13'd4096;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SRC_BITS:  src_reg     <= cfg_data[2:0];
                REG_PAL_COUNT: pal_cnt_reg <= cfg_data[8:0];
                REG_OUT_FMT:   fmt_reg     <= cfg_data[1:0];
                REG_WIDTH:     width_reg   <= cfg_data[11:0];
                REG_HEIGHT:    height_reg  <= cfg_data[11:0];
                REG_X_OFFSET:  xoff_reg    <= cfg_data[11:0];
                REG_DST_W:     dst_w_reg   <= cfg_data;
                REG_DST_H:     dst_h_reg   <= cfg_data;
                default:       src_reg     <= src_reg;
            endcase
        end
    end

    // Derived configuration, valid in the cycle right after a register write.
    always_comb
    begin
        geo_ok = width_reg != 12'd0 && height_reg != 12'd0
                 && right <= dst_w_reg && {{(32-13){1'b0}}, right} <= MAX_COLUMNS
                 && {1'b0, height_reg} <= dst_h_reg;
        ncol   = (pal_cnt_reg < 9'(PALETTE_ENTRIES)) ? pal_cnt_reg
                                                      : 9'(PALETTE_ENTRIES);
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && in_data.op == OP_PALETTE
            && {1'b0, in_data.pal_index} < 9'(PALETTE_ENTRIES))
        begin
            palette_mem[in_data.pal_index[PAL_AW-1:0]] <=
                {in_data.pal_red, in_data.pal_green, in_data.pal_blue};
        end
        rd_reg <= palette_mem[pidx_reg[PAL_AW-1:0]];
    end

    always_comb
    begin
        buf_next      = buf_reg;
        bits_next     = bits_reg;
        phase_next    = phase_reg;
        partial_next  = partial_reg;
        rbc_next      = rbc_reg;
        col_next      = col_reg;
        rowc_next     = rowc_reg;
        fin_next      = fin_reg;
        pend_next     = pend_reg;
        use_pal_next  = use_pal_reg;
        pidx_next     = pidx_reg;
        prgb_next     = prgb_reg;
        palpha_next   = palpha_reg;
        idx_pend_next = idx_pend_reg;
        rowend_next   = rowend_reg;
        lookup_next   = 1'b0;
        mod_busy_next = mod_busy_reg;
        mod_val_next  = mod_val_reg;
        last_pix      = 1'b0;

        if (cmd.take_byte)
        begin
            rbc_next    = rbc_reg + 15'd1;
            rowend_next = 1'b1;
            if (col_reg < width_reg)
            begin
                unique case (src_reg)
                    SRC_1BPP, SRC_2BPP, SRC_4BPP:
                    begin
                        buf_next      = in_data.data_byte;
                        bits_next     = 4'd8;
                        pend_next     = 1'b1;
                        idx_pend_next = 1'b1;
                    end
                    SRC_8BPP:
                    begin
                        pend_next    = 1'b1;
                        palpha_next  = 8'hff;
                        use_pal_next = ncol != 9'd0;
                        prgb_next    = 24'd0;
                        mod_val_next = in_data.data_byte;
                        pidx_next    = in_data.data_byte;
                        if (ncol != 9'd0)
                        begin
                            if ({1'b0, in_data.data_byte} >= ncol)
                                mod_busy_next = 1'b1;
                            else
                                lookup_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (phase_reg < ((src_reg == SRC_24BPP) ? 2'd2 : 2'd3))
                        begin
                            unique case (phase_reg)
                                2'd0:    partial_next[7:0]   = in_data.data_byte;
                                2'd1:    partial_next[15:8]  = in_data.data_byte;
                                default: partial_next[23:16] = in_data.data_byte;
                            endcase
                            phase_next = phase_reg + 2'd1;
                        end
                        else
                        begin
                            phase_next   = 2'd0;
                            pend_next    = 1'b1;
                            use_pal_next = 1'b0;
                            if (src_reg == SRC_24BPP)
                            begin
                                prgb_next   = {in_data.data_byte, partial_reg[15:0]};
                                palpha_next = 8'hff;
                            end
                            else
                            begin
                                prgb_next   = partial_reg;
                                palpha_next = in_data.data_byte;
                            end
                        end
                    end
                endcase
            end
        end
        else if (mod_busy_reg)
        begin
            if ({1'b0, mod_val_reg} >= ncol)
                mod_val_next = 8'({1'b0, mod_val_reg} - ncol);
            else
            begin
                mod_busy_next = 1'b0;
                pidx_next     = mod_val_reg;
                lookup_next   = 1'b1;
            end
        end
        else if (idx_pend_reg)
        begin
            // Set up the next sub-byte pixel of the buffered byte.
            idx_pend_next = 1'b0;
            palpha_next   = 8'hff;
            use_pal_next  = ncol >= need;
            pidx_next     = v;
            prgb_next     = {3{8'(v * grey)}};
            lookup_next   = ncol >= need;
        end
        else if (cmd.emit && ready_pix)
        begin
            col_next = col_reg + 12'd1;
            if (src_reg <= SRC_4BPP)
            begin
                bits_next = bits_sub;
                if (bits_sub >= bpp && col_next < width_reg)
                    idx_pend_next = 1'b1;
                else
                    last_pix = 1'b1;
            end
            else
                last_pix = 1'b1;
            if (last_pix)
                pend_next = 1'b0;
        end

        // Row end check once the byte's pixels are all out.
        if (rowend_reg && !pend_reg && !cmd.take_byte)
        begin
            rowend_next = 1'b0;
            if (!(col_reg < width_reg) && rbc_reg[1:0] == 2'd0)
            begin
                rbc_next   = 15'd0;
                col_next   = 12'd0;
                bits_next  = 4'd0;
                phase_next = 2'd0;
                if (rowc_reg == 12'd0)
                    fin_next = 1'b1;
                else
                    rowc_next = rowc_reg - 12'd1;
            end
        end

        if (cmd.restart)
        begin
            buf_next      = 8'd0;
            bits_next     = 4'd0;
            phase_next    = 2'd0;
            partial_next  = 24'd0;
            rbc_next      = 15'd0;
            col_next      = 12'd0;
            rowc_next     = ((cfg_index == REG_HEIGHT) ? cfg_data[11:0] : height_reg) - 12'd1;
            fin_next      = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg      <= 8'd0;
            bits_reg     <= 4'd0;
            phase_reg    <= 2'd0;
            partial_reg  <= 24'd0;
            rbc_reg      <= 15'd0;
            col_reg      <= 12'd0;
            rowc_reg     <= 12'hfff;
            fin_reg      <= 1'b0;
            pend_reg     <= 1'b0;
            idx_pend_reg <= 1'b0;
            rowend_reg   <= 1'b0;
            lookup_reg   <= 1'b0;
            mod_busy_reg <= 1'b0;
        end
        else
        begin
            buf_reg      <= buf_next;
            bits_reg     <= bits_next;
            phase_reg    <= phase_next;
            partial_reg  <= partial_next;
            rbc_reg      <= rbc_next;
            col_reg      <= col_next;
            rowc_reg     <= rowc_next;
            fin_reg      <= fin_next;
            pend_reg     <= pend_next;
            idx_pend_reg <= idx_pend_next;
            rowend_reg   <= rowend_next;
            lookup_reg   <= lookup_next;
            mod_busy_reg <= mod_busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        use_pal_reg <= use_pal_next;
        pidx_reg    <= pidx_next;
        prgb_reg    <= prgb_next;
        palpha_reg  <= palpha_next;
        mod_val_reg <= mod_val_next;
    end

    // The emit command is only honored on a settled pixel; idle cycles keep the register.
    always_ff @(posedge clk)
    begin
        if (cmd.emit && ready_pix && !cmd.take_byte && !mod_busy_reg && !idx_pend_reg)
        begin
            out_reg.column       <= xoff_reg + col_reg;
            out_reg.row          <= rowc_reg;
            out_reg.pixel_word   <= pack_pixel(fmt_reg, use_pal_reg ? rd_reg : prgb_reg,
                                               palpha_reg);
            out_reg.alpha        <= palpha_reg;
            out_reg.last_of_item <= last_pix;
        end
    end

    assign out_data = out_reg;

endmodule
